// ===== src/sdq_pkg.sv =====
// Shared types and constants for the sorted deadline queue.
package sdq_pkg;

   localparam int IdW       = 6;
   localparam int NumIds    = 64;
   localparam int TimeoutW  = 32;
   localparam int DeadlineW = 64;
   localparam int CountW    = 7;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COMPACT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic [IdW-1:0]       id;
      logic [DeadlineW-1:0] deadline;
   } entry_type;

   typedef struct packed {
      logic                 insert;
      logic                 remove;
      logic                 compact;
      logic [IdW-1:0]       id;
      logic [DeadlineW-1:0] deadline;
   } cell_cmd_type;

   typedef struct packed {
      logic              valid;
      logic              error;
      logic [CountW-1:0] count;
   } rsp_ctl_type;

endpackage

// ===== src/sdq_cell.sv =====
// One cell of the sorted chain: holds one queued entry and trades with its neighbors.
module sdq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  sdq_pkg::cell_cmd_type cmd,
   input  sdq_pkg::entry_type   left_entry,
   input  logic                 left_ge,
   input  sdq_pkg::entry_type   right_entry,
   output sdq_pkg::entry_type   entry,
   output logic                 ge
);

   logic                          valid_ff;
   logic                          valid_in;
   logic [sdq_pkg::IdW-1:0]       id_ff;
   logic [sdq_pkg::IdW-1:0]       id_in;
   logic [sdq_pkg::DeadlineW-1:0] deadline_ff;
   logic [sdq_pkg::DeadlineW-1:0] deadline_in;

   assign entry.valid    = valid_ff;
   assign entry.id       = id_ff;
   assign entry.deadline = deadline_ff;
   assign ge             = !valid_ff || (deadline_ff >= cmd.deadline);

   always_comb begin
      valid_in    = valid_ff;
      id_in       = id_ff;
      deadline_in = deadline_ff;
      if (cmd.insert) begin
         if (left_ge) begin
            valid_in    = left_entry.valid;
            id_in       = left_entry.id;
            deadline_in = left_entry.deadline;
         end else if (ge) begin
            valid_in    = 1'b1;
            id_in       = cmd.id;
            deadline_in = cmd.deadline;
         end
      end
      if (cmd.remove && valid_ff && (id_ff == cmd.id)) begin
         valid_in = 1'b0;
      end
      if (cmd.compact) begin
         if (!valid_ff && right_entry.valid) begin
            valid_in    = 1'b1;
            id_in       = right_entry.id;
            deadline_in = right_entry.deadline;
         end else if (valid_ff && !left_entry.valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      deadline_ff <= deadline_in;
   end

endmodule

// ===== src/sdq_ctrl.sv =====
// Sequencer for the sorted deadline queue: request capture, queued flags, count.
module sdq_ctrl #(
   parameter int MAX_THREADS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_opcode,
   input  logic [sdq_pkg::IdW-1:0]        req_thread_id,
   input  logic [sdq_pkg::TimeoutW-1:0]   req_timeout_ms,
   input  logic [sdq_pkg::DeadlineW-1:0]  req_current_time,
   output sdq_pkg::cell_cmd_type          cmd,
   output sdq_pkg::rsp_ctl_type           rsp_ctl
);

   localparam int CntW = $clog2(MAX_THREADS);

   sdq_pkg::state_type state_ff;
   sdq_pkg::state_type state_in;

   logic                          op_ff;
   logic [sdq_pkg::IdW-1:0]       id_ff;
   logic [sdq_pkg::DeadlineW-1:0] deadline_ff;
   logic                          error_ff;
   logic                          error_in;
   logic [sdq_pkg::NumIds-1:0]    queued_ff;
   logic [sdq_pkg::CountW-1:0]    count_ff;
   logic [CntW-1:0]               sweep_ff;
   logic                          accept;
   logic                          do_add;
   logic                          do_remove;

   assign accept    = start && (state_ff == sdq_pkg::ST_IDLE);
   assign do_add    = (state_ff == sdq_pkg::ST_EXEC) && !error_ff
                      && (op_ff == sdq_pkg::OP_ADD);
   assign do_remove = (state_ff == sdq_pkg::ST_EXEC) && !error_ff
                      && (op_ff == sdq_pkg::OP_REMOVE);

   always_comb begin
      if (32'(req_thread_id) >= 32'(MAX_THREADS)) begin
         error_in = 1'b1;
      end else if (req_opcode == sdq_pkg::OP_ADD) begin
         error_in = queued_ff[req_thread_id];
      end else begin
         error_in = !queued_ff[req_thread_id];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      busy            = (state_ff != sdq_pkg::ST_IDLE);
      cmd.insert      = do_add;
      cmd.remove      = do_remove;
      cmd.compact     = (state_ff == sdq_pkg::ST_COMPACT);
      cmd.id          = id_ff;
      cmd.deadline    = deadline_ff;
      rsp_ctl.valid   = (state_ff == sdq_pkg::ST_RESPOND);
      rsp_ctl.error   = error_ff;
      rsp_ctl.count   = count_ff;
      unique case (state_ff)
         sdq_pkg::ST_IDLE: begin
            if (start) begin
               state_in = sdq_pkg::ST_EXEC;
            end
         end
         sdq_pkg::ST_EXEC: begin
            state_in = do_remove ? sdq_pkg::ST_COMPACT : sdq_pkg::ST_RESPOND;
         end
         sdq_pkg::ST_COMPACT: begin
            if (sweep_ff == '0) begin
               state_in = sdq_pkg::ST_RESPOND;
            end
         end
         sdq_pkg::ST_RESPOND: begin
            state_in = sdq_pkg::ST_IDLE;
         end
         default: begin
            state_in = sdq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_opcode;
         id_ff       <= req_thread_id;
         deadline_ff <= req_current_time + sdq_pkg::DeadlineW'(req_timeout_ms);
         error_ff    <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sdq_pkg::ST_EXEC) begin
         sweep_ff <= CntW'(MAX_THREADS - 1);
      end else if (state_ff == sdq_pkg::ST_COMPACT) begin
         sweep_ff <= sweep_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff <= '0;
         count_ff  <= '0;
      end else if (do_add) begin
         queued_ff[id_ff] <= 1'b1;
         count_ff         <= count_ff + 1'b1;
      end else if (do_remove) begin
         queued_ff[id_ff] <= 1'b0;
         count_ff         <= count_ff - 1'b1;
      end
   end

endmodule

// ===== src/sorted_deadline_queue.sv =====
// Top level of the sorted deadline queue: sequencer plus a chain of entry cells.
// The queue holds thread slots in a row of MAX_THREADS cells ordered by deadline,
// cell 0 being the head. Raise start with a request while busy is low; each request
// gives exactly one response, presented for one cycle with rsp_valid high, and the
// response must be taken in that cycle. An add forms and registers the deadline at
// accept; in the execute state every cell compares against it and the chain shifts
// right by one in place; the response state follows. A remove empties the matching
// cell in the execute state, then in the compaction state the hole moves toward the
// tail one cell per cycle, over a sweep counted down from MAX_THREADS - 1 to zero.
// Rejected requests go from execute straight to response. Reset clears the queue.
module sorted_deadline_queue #(
   parameter int MAX_THREADS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [sdq_pkg::IdW-1:0]       req_thread_id,
   input  logic [sdq_pkg::TimeoutW-1:0]  req_timeout_ms,
   input  logic [sdq_pkg::DeadlineW-1:0] req_current_time,
   output logic                          rsp_valid,
   output logic [sdq_pkg::IdW-1:0]       rsp_head_thread,
   output logic [sdq_pkg::DeadlineW-1:0] rsp_earliest_deadline,
   output logic [sdq_pkg::CountW-1:0]    rsp_entry_count,
   output logic                          rsp_queue_empty,
   output logic                          rsp_op_error
);

   sdq_pkg::cell_cmd_type cmd;
   sdq_pkg::rsp_ctl_type  rsp_ctl;
   sdq_pkg::entry_type    chain [MAX_THREADS];
   logic                  ge_chain [MAX_THREADS];

   sdq_ctrl #(
      .MAX_THREADS (MAX_THREADS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_thread_id    (req_thread_id),
      .req_timeout_ms   (req_timeout_ms),
      .req_current_time (req_current_time),
      .cmd              (cmd),
      .rsp_ctl          (rsp_ctl)
   );

   for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
      sdq_pkg::entry_type left_entry;
      sdq_pkg::entry_type right_entry;
      logic               left_ge;

      if (i == 0) begin : g_head
         assign left_entry.valid    = 1'b1;
         assign left_entry.id       = '0;
         assign left_entry.deadline = '0;
         assign left_ge             = 1'b0;
      end else begin : g_body
         assign left_entry = chain[i-1];
         assign left_ge    = ge_chain[i-1];
      end

      if (i == MAX_THREADS - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = chain[i+1];
      end

      sdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_ge     (left_ge),
         .right_entry (right_entry),
         .entry       (chain[i]),
         .ge          (ge_chain[i])
      );
   end

   assign rsp_valid             = rsp_ctl.valid;
   assign rsp_head_thread       = chain[0].valid ? chain[0].id : '0;
   assign rsp_earliest_deadline = chain[0].valid ? chain[0].deadline : '0;
   assign rsp_entry_count       = rsp_ctl.count;
   assign rsp_queue_empty       = (rsp_ctl.count == '0);
   assign rsp_op_error          = rsp_ctl.error;

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_entry_count == '0) == !chain[0].valid))
      else $error("head cell occupancy disagrees with entry count");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted item");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("sequencer not idle after a response");

endmodule

// ===== sim/sorted_deadline_queue_tb.sv =====
// Self-checking testbench for the sorted deadline queue: directed and random add/remove traffic.
`timescale 1ns / 1ps

typedef struct packed {
   logic [sdq_pkg::IdW-1:0]       head;
   logic [sdq_pkg::DeadlineW-1:0] deadline;
   logic [sdq_pkg::CountW-1:0]    count;
   logic                          empty;
   logic                          error;
} queue_status_type;

class deadline_scoreboard;
   logic [sdq_pkg::DeadlineW-1:0] slot_time [sdq_pkg::NumIds];
   bit                            slot_waiting [sdq_pkg::NumIds];
   int                            order [$];
   queue_status_type              expected_status [$];
   int                            errors;

   function int depth();
      return order.size();
   endfunction

   function bit waiting(input logic [sdq_pkg::IdW-1:0] id);
      return slot_waiting[id];
   endfunction

   function logic [sdq_pkg::IdW-1:0] pick_waiting();
      return sdq_pkg::IdW'(order[$urandom_range(order.size() - 1)]);
   endfunction

   function int pending();
      return expected_status.size();
   endfunction

   function void note_request(input logic op, input logic [sdq_pkg::IdW-1:0] id,
                              input logic [sdq_pkg::TimeoutW-1:0] timeout_ms,
                              input logic [sdq_pkg::DeadlineW-1:0] now_ms);
      logic [sdq_pkg::DeadlineW-1:0] due;
      int                            pos;
      queue_status_type              status;
      status.error = 1'b0;
      if (op == sdq_pkg::OP_ADD) begin
         if (slot_waiting[id]) begin
            status.error = 1'b1;
         end else begin
            due = now_ms + {{(sdq_pkg::DeadlineW - sdq_pkg::TimeoutW){1'b0}}, timeout_ms};
            pos = 0;
            while (pos < order.size() && slot_time[order[pos]] < due) pos++;
            order.insert(pos, int'(id));
            slot_time[id]    = due;
            slot_waiting[id] = 1'b1;
         end
      end else begin
         if (!slot_waiting[id]) begin
            status.error = 1'b1;
         end else begin
            pos = 0;
            while (order[pos] != int'(id)) pos++;
            order.delete(pos);
            slot_time[id]    = '0;
            slot_waiting[id] = 1'b0;
         end
      end
      status.count = sdq_pkg::CountW'(order.size());
      status.empty = (order.size() == 0);
      if (order.size() == 0) begin
         status.head     = '0;
         status.deadline = '0;
      end else begin
         status.head     = sdq_pkg::IdW'(order[0]);
         status.deadline = slot_time[order[0]];
      end
      expected_status.push_back(status);
   endfunction

   function void check_response(input queue_status_type got);
      queue_status_type want;
      if (expected_status.size() == 0) begin
         errors++;
         if (errors <= 10) $display("%0t: response with no request outstanding", $time);
         return;
      end
      want = expected_status.pop_front();
      if (got !== want) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: response mismatch", $time);
            $display("   expected head %0d deadline %h count %0d empty %b error %b",
                     want.head, want.deadline, want.count, want.empty, want.error);
            $display("   actual   head %0d deadline %h count %0d empty %b error %b",
                     got.head, got.deadline, got.count, got.empty, got.error);
         end
      end
   endfunction

   function void close();
      if (expected_status.size() != 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: %0d responses never arrived", $time, expected_status.size());
      end
   endfunction
endclass

module sorted_deadline_queue_tb;
   logic                          clock;
   logic                          reset            = 1'b1;
   logic                          start            = 1'b0;
   logic                          busy;
   logic                          req_opcode       = sdq_pkg::OP_ADD;
   logic [sdq_pkg::IdW-1:0]       req_thread_id    = '0;
   logic [sdq_pkg::TimeoutW-1:0]  req_timeout_ms   = '0;
   logic [sdq_pkg::DeadlineW-1:0] req_current_time = '0;
   logic                          rsp_valid;
   logic [sdq_pkg::IdW-1:0]       rsp_head_thread;
   logic [sdq_pkg::DeadlineW-1:0] rsp_earliest_deadline;
   logic [sdq_pkg::CountW-1:0]    rsp_entry_count;
   logic                          rsp_queue_empty;
   logic                          rsp_op_error;

   deadline_scoreboard sb = new;
   int                 idle_pct = 9;

   sorted_deadline_queue #(
      .MAX_THREADS(sdq_pkg::NumIds)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_thread_id         (req_thread_id),
      .req_timeout_ms        (req_timeout_ms),
      .req_current_time      (req_current_time),
      .rsp_valid             (rsp_valid),
      .rsp_head_thread       (rsp_head_thread),
      .rsp_earliest_deadline (rsp_earliest_deadline),
      .rsp_entry_count       (rsp_entry_count),
      .rsp_queue_empty       (rsp_queue_empty),
      .rsp_op_error          (rsp_op_error)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(queue_status_type'({rsp_head_thread, rsp_earliest_deadline,
                                               rsp_entry_count, rsp_queue_empty,
                                               rsp_op_error}));
   end

   task automatic issue(input logic op, input logic [sdq_pkg::IdW-1:0] id,
                        input logic [sdq_pkg::TimeoutW-1:0] timeout_ms,
                        input logic [sdq_pkg::DeadlineW-1:0] now_ms);
      bit taken;
      bit offer;
      taken = 1'b0;
      req_opcode       <= op;
      req_thread_id    <= id;
      req_timeout_ms   <= timeout_ms;
      req_current_time <= now_ms;
      while (!taken) begin
         offer = ($urandom_range(99) >= idle_pct);
         start <= offer;
         @(posedge clock);
         taken = offer && !busy;
      end
      sb.note_request(op, id, timeout_ms, now_ms);
   endtask

   initial begin : stimulus
      localparam logic [63:0] TimeMax = 64'hFFFF_FFFF_FFFF_FFFF;
      logic                          op;
      logic [sdq_pkg::IdW-1:0]       id;
      logic [sdq_pkg::TimeoutW-1:0]  timeout_ms;
      logic [sdq_pkg::DeadlineW-1:0] now_ms;
      logic [sdq_pkg::DeadlineW-1:0] clock_ms;
      int                            n;
      int                            add_pct;
      int                            guard;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, ties, wraparound, rejected ops, unlink at head/middle/tail
      issue(sdq_pkg::OP_REMOVE, 6'd5, 32'hFFFF_FFFF, TimeMax);
      issue(sdq_pkg::OP_ADD, 6'd0, 32'd100, 64'd0);
      issue(sdq_pkg::OP_ADD, 6'd63, 32'd100, 64'd0);
      issue(sdq_pkg::OP_ADD, 6'd7, 32'd0, 64'd100);
      issue(sdq_pkg::OP_ADD, 6'd12, 32'hFFFF_FFFF, TimeMax);
      issue(sdq_pkg::OP_ADD, 6'd20, 32'd0, 64'd0);
      issue(sdq_pkg::OP_ADD, 6'd33, 32'd0, TimeMax);
      issue(sdq_pkg::OP_ADD, 6'd63, 32'd1, 64'd0);
      issue(sdq_pkg::OP_ADD, 6'd20, 32'd5, 64'd0);
      issue(sdq_pkg::OP_REMOVE, 6'd0, 32'd0, 64'd0);
      issue(sdq_pkg::OP_REMOVE, 6'd0, 32'd0, 64'd0);
      issue(sdq_pkg::OP_REMOVE, 6'd20, 32'hFFFF_FFFF, 64'd0);
      issue(sdq_pkg::OP_REMOVE, 6'd33, 32'd0, TimeMax);
      issue(sdq_pkg::OP_ADD, 6'd45, 32'd50, 64'd60);
      issue(sdq_pkg::OP_REMOVE, 6'd63, 32'd0, 64'd0);
      issue(sdq_pkg::OP_REMOVE, 6'd7, 32'd0, 64'd0);
      issue(sdq_pkg::OP_REMOVE, 6'd12, 32'd0, 64'd0);
      issue(sdq_pkg::OP_REMOVE, 6'd45, 32'd0, 64'd0);
      issue(sdq_pkg::OP_ADD, 6'd1, 32'hFFFF_FFFF, 64'd0);
      issue(sdq_pkg::OP_ADD, 6'd62, 32'd0, 64'h8000_0000_0000_0000);
      issue(sdq_pkg::OP_REMOVE, 6'd1, 32'd0, 64'd0);
      issue(sdq_pkg::OP_REMOVE, 6'd62, 32'd0, 64'd0);

      // random: alternate fill and drain stretches, clock crosses the 64-bit wrap
      clock_ms = 64'hFFFF_FFFF_FFFF_FC00;
      for (n = 0; n < 960; n++) begin
         idle_pct = (n < 320) ? 9 : (n < 640) ? 48 : 0;
         add_pct  = ((n / 120) % 2 == 0) ? 85 : 20;
         clock_ms = clock_ms + sdq_pkg::DeadlineW'($urandom_range(0, 3));
         now_ms   = ($urandom_range(9) == 0) ? {$urandom, $urandom} : clock_ms;
         case ($urandom_range(3))
            0: timeout_ms = $urandom_range(0, 3);
            1, 2: timeout_ms = $urandom_range(0, 1000);
            default: timeout_ms = $urandom;
         endcase
         op = ($urandom_range(99) < add_pct) ? sdq_pkg::OP_ADD : sdq_pkg::OP_REMOVE;
         if ($urandom_range(19) == 0) begin
            id = sdq_pkg::IdW'($urandom_range(63));
         end else if (op == sdq_pkg::OP_ADD && sb.depth() < sdq_pkg::NumIds) begin
            do id = sdq_pkg::IdW'($urandom_range(63)); while (sb.waiting(id));
         end else if (op == sdq_pkg::OP_REMOVE && sb.depth() > 0) begin
            id = sb.pick_waiting();
         end else begin
            id = sdq_pkg::IdW'($urandom_range(63));
         end
         issue(op, id, timeout_ms, now_ms);
      end
      start <= 1'b0;

      guard = 0;
      while (sb.pending() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (sdq_pkg::NumIds + 8) @(posedge clock);
      sb.close();
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
